// ===== hdl/bks_pkg.sv =====
// Shared types, widths and codes for the B-spline knot span search block.
// Used by the shared divider, the top level and the testbench; depends on nothing.

package bks_pkg;

   localparam int DATA_W     = 32;  // Q15.16 knot and parameter width
   localparam int SUM_W      = 35;  // sum of up to seven knots
   localparam int DEG_W      = 3;   // degree register width
   localparam int CNT_W      = 7;   // knot count register width
   localparam int IDX_W      = 7;   // internal knot index width (holds 64)
   localparam int KIDX_W     = 6;   // knot index field width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int KNOTS_MAX_DEFAULT = 64;
   localparam int COUNT_CAP         = 64;

   localparam logic [DEG_W-1:0] DEGREE_RESET     = 3'd3;
   localparam logic [CNT_W-1:0] KNOT_COUNT_RESET = 7'd8;

   // Request actions.
   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_SEARCH  = 2'd1;
   localparam logic [1:0] ACT_AVERAGE = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   // Search modes.
   localparam logic [1:0] MODE_LEFT     = 2'd0;
   localparam logic [1:0] MODE_LEFT_EQ  = 2'd1;
   localparam logic [1:0] MODE_RIGHT    = 2'd2;
   localparam logic [1:0] MODE_RIGHT_EQ = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_COUNT = 2'd1;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [DEG_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/bks_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the knot vector of the span search block.

module bks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bks_div.sv =====
// Iterative restoring divider: a signed knot sum divided by the degree,
// one quotient bit per cycle, truncated toward zero. Uses bks_pkg.

module bks_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bks_pkg::div_req_type div_req,
   output bks_pkg::div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(bks_pkg::SUM_W + 1);

   logic [bks_pkg::SUM_W-1:0] q_ff, q_in;
   logic [bks_pkg::DEG_W-1:0] rem_ff, rem_in;
   logic [bks_pkg::DEG_W-1:0] dvs_ff, dvs_in;
   logic                      neg_ff, neg_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [bks_pkg::DEG_W:0]   rem_shift;
   logic [bks_pkg::DEG_W:0]   rem_next;
   logic                      fits;
   logic [bks_pkg::SUM_W-1:0] magnitude;
   logic [bks_pkg::SUM_W-1:0] signed_q;

   assign magnitude = div_req.dividend[bks_pkg::SUM_W-1] ?
                      bks_pkg::SUM_W'(-div_req.dividend) :
                      bks_pkg::SUM_W'(div_req.dividend);
   assign rem_shift = {rem_ff, q_ff[bks_pkg::SUM_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign rem_next  = fits ? rem_shift - {1'b0, dvs_ff} : rem_shift;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         q_in    = magnitude;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         neg_in  = div_req.dividend[bks_pkg::SUM_W-1];
         step_in = STEP_W'(bks_pkg::SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in    = {q_ff[bks_pkg::SUM_W-2:0], fits};
         rem_in  = rem_next[bks_pkg::DEG_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign signed_q         = neg_ff ? -q_ff : q_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = signed'(signed_q[bks_pkg::DATA_W-1:0]);

   // A new division is never started over one still running.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The partial remainder stays below the divisor while iterating.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

   // The last iteration is followed by the done pulse.
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && step_ff == STEP_W'(1)) |=> done_ff)
      else $error("divider did not finish");

endmodule

// ===== hdl/bspline_knot_span_search.sv =====
// Top level of the B-spline knot span search: knot RAM, search sequencer,
// averaging adder and the shared divider. Uses bks_pkg, bks_ram and bks_div.
//
// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_stall  action, search_mode, knot_index, value
// rsp_*     out        rsp_valid / rsp_stall  span_index, average, range_error
// csr_*     in         csr_valid / csr_ready  index, data (degree, knot_count)
//
// A knot write, an unknown action or an average whose range runs past the knot
// count is answered in the cycle after it is accepted. A span search visits
// the knots one at a time, since a single RAM read port feeds the compare. An
// average sums the degree knots after its base slot, then divides the sum by
// the degree in the bit-serial divider (35 quotient bits).
// Reset is synchronous and clears control state only; the knot RAM is not
// cleared. The block takes a new request only when idle and when the result
// register is empty or being emptied in the same cycle.

module bspline_knot_span_search #(
   parameter int KNOTS_MAX = bks_pkg::KNOTS_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [1:0]                            req_search_mode,
   input  logic [bks_pkg::KIDX_W-1:0]            req_knot_index,
   input  logic signed [bks_pkg::DATA_W-1:0]     req_value,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bks_pkg::KIDX_W-1:0]            rsp_span_index,
   output logic signed [bks_pkg::DATA_W-1:0]     rsp_average,
   output logic                                  rsp_range_error,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bks_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bks_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int AW = $clog2(KNOTS_MAX);
   // The effective knot count is limited by the store depth and by 64.
   localparam int CAP = (KNOTS_MAX < bks_pkg::COUNT_CAP) ? KNOTS_MAX : bks_pkg::COUNT_CAP;
   localparam logic [bks_pkg::CNT_W-1:0] CAP_W = bks_pkg::CNT_W'(CAP);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SUM    = 4'b0100,
      ST_DIVIDE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [bks_pkg::DEG_W-1:0] degree_ff, degree_in;
   logic [bks_pkg::CNT_W-1:0] count_ff, count_in;

   // Sequencer working registers.
   logic [bks_pkg::IDX_W-1:0]       i_ff, i_in;
   logic                            right_ff, right_in;
   logic                            equal_ff, equal_in;
   logic                            moved_ff, moved_in;
   logic signed [bks_pkg::DATA_W-1:0] prev_ff, prev_in;
   logic signed [bks_pkg::DATA_W-1:0] u_ff, u_in;
   logic signed [bks_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic [bks_pkg::DEG_W-1:0]       cnt_ff, cnt_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bks_pkg::KIDX_W-1:0]      rsp_span_ff, rsp_span_in;
   logic signed [bks_pkg::DATA_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic                            rsp_err_ff, rsp_err_in;

   // Effective degree and count.
   logic [bks_pkg::DEG_W-1:0] p;
   logic [bks_pkg::CNT_W-1:0] n;
   logic [bks_pkg::IDX_W-1:0] p_idx;

   // Signed views for the loop bounds.
   logic signed [8:0] n_s, p_s, i_s, right_start_s;
   logic [bks_pkg::IDX_W-1:0] right_start;

   logic req_accept;
   logic req_right, req_equal;
   logic avg_error;

   // RAM ports.
   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_rd_addr;
   logic [bks_pkg::IDX_W-1:0]       rd_idx;
   logic [bks_pkg::DATA_W-1:0]      ram_rd_data;
   logic signed [bks_pkg::DATA_W-1:0] d;

   // Search step decision.
   logic bound_ok, cmp_ok, dup_stop, step;

   bks_pkg::div_req_type div_req;
   bks_pkg::div_rsp_type div_rsp;

   assign p     = (degree_ff == '0) ? bks_pkg::DEG_W'(1) : degree_ff;
   assign n     = (count_ff > CAP_W) ? CAP_W : count_ff;
   assign p_idx = {4'b0, p};

   assign n_s = $signed({2'b00, n});
   assign p_s = $signed({6'b000000, p});
   assign i_s = $signed({2'b00, i_ff});

   // The right searches start at n-1-p, or at zero when that is negative.
   assign right_start_s = n_s - 9'sd1 - p_s;
   assign right_start   = right_start_s[8] ? '0 : right_start_s[bks_pkg::IDX_W-1:0];

   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);

   assign req_right = (req_search_mode == bks_pkg::MODE_RIGHT) ||
                      (req_search_mode == bks_pkg::MODE_RIGHT_EQ);
   assign req_equal = (req_search_mode == bks_pkg::MODE_LEFT_EQ) ||
                      (req_search_mode == bks_pkg::MODE_RIGHT_EQ);

   // The average range is valid only when base + degree stays below the count.
   assign avg_error = ({1'b0, req_knot_index} + p_idx) >= n;

   // Writes to slots at or beyond the store depth are dropped.
   assign ram_wr_en = req_accept && (req_action == bks_pkg::ACT_WRITE) &&
                      ({26'b0, req_knot_index} < 32'(KNOTS_MAX));

   // Read address. The RAM read port is registered, so while a search walks
   // the address runs one knot ahead of the knot being compared.
   always_comb begin
      rd_idx = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_action == bks_pkg::ACT_AVERAGE) begin
               rd_idx = {1'b0, req_knot_index} + 7'd1;
            end else if (req_right) begin
               rd_idx = right_start - 7'd1;
            end else begin
               rd_idx = p_idx + 7'd1;
            end
         end
         ST_SEARCH: begin
            rd_idx = right_ff ? i_ff - 7'd2 : i_ff + 7'd2;
         end
         ST_SUM: begin
            rd_idx = i_ff;
         end
         default: begin
            rd_idx = '0;
         end
      endcase
   end

   assign ram_rd_addr = AW'(rd_idx);

   bks_ram #(
      .WIDTH(bks_pkg::DATA_W),
      .DEPTH(KNOTS_MAX)
   ) u_knot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(AW'(req_knot_index)),
      .wr_data(req_value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign d = signed'(ram_rd_data);

   // One step of the linear search. In the search state d holds the neighbor
   // knot (i+1 for the left searches, i-1 for the right searches) and prev_ff
   // holds knot i once the index has moved.
   always_comb begin
      if (right_ff) begin
         bound_ok = equal_ff ? (i_s - 9'sd1 >= p_s) : (i_s - 9'sd1 > p_s);
         cmp_ok   = equal_ff ? (u_ff <= d) : (u_ff < d);
      end else begin
         bound_ok = (i_s + 9'sd1) < (n_s - p_s);
         cmp_ok   = equal_ff ? (u_ff >= d) : (u_ff > d);
      end
      // The "or equal" searches stop right after stepping onto a repeated knot.
      dup_stop = equal_ff && moved_ff && (d == prev_ff);
      step     = !dup_stop && bound_ok && cmp_ok;
   end

   always_comb begin
      state_in     = state_ff;
      degree_in    = degree_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      right_in     = right_ff;
      equal_in     = equal_ff;
      moved_in     = moved_ff;
      prev_in      = prev_ff;
      u_in         = u_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_span_in  = rsp_span_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_err_in   = rsp_err_ff;

      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = p;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         if (csr_index == bks_pkg::CSR_DEGREE) begin
            degree_in = csr_data[bks_pkg::DEG_W-1:0];
         end else if (csr_index == bks_pkg::CSR_KNOT_COUNT) begin
            count_in = csr_data[bks_pkg::CNT_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  bks_pkg::ACT_SEARCH: begin
                     right_in = req_right;
                     equal_in = req_equal;
                     moved_in = 1'b0;
                     u_in     = req_value;
                     i_in     = req_right ? right_start : p_idx;
                     state_in = ST_SEARCH;
                  end
                  bks_pkg::ACT_AVERAGE: begin
                     if (avg_error) begin
                        rsp_valid_in = 1'b1;
                        rsp_span_in  = '0;
                        rsp_avg_in   = '0;
                        rsp_err_in   = 1'b1;
                     end else begin
                        acc_in   = '0;
                        cnt_in   = '0;
                        i_in     = {1'b0, req_knot_index} + 7'd2;
                        state_in = ST_SUM;
                     end
                  end
                  default: begin
                     // Knot writes and the unused action answer with zeros.
                     rsp_valid_in = 1'b1;
                     rsp_span_in  = '0;
                     rsp_avg_in   = '0;
                     rsp_err_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (step) begin
               i_in     = right_ff ? i_ff - 7'd1 : i_ff + 7'd1;
               prev_in  = d;
               moved_in = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_span_in  = i_ff[bks_pkg::KIDX_W-1:0];
               rsp_avg_in   = '0;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + {{(bks_pkg::SUM_W - bks_pkg::DATA_W){d[bks_pkg::DATA_W-1]}}, d};
            cnt_in = cnt_ff + bks_pkg::DEG_W'(1);
            i_in   = i_ff + 7'd1;
            if (cnt_ff == p - bks_pkg::DEG_W'(1)) begin
               div_req.start    = 1'b1;
               div_req.dividend = acc_in;
               state_in         = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_span_in  = '0;
               rsp_avg_in   = div_rsp.quotient;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   bks_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         degree_ff    <= bks_pkg::DEGREE_RESET;
         count_ff     <= bks_pkg::KNOT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         moved_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         moved_ff     <= moved_in;
      end
      i_ff        <= i_in;
      right_ff    <= right_in;
      equal_ff    <= equal_in;
      prev_ff     <= prev_in;
      u_ff        <= u_in;
      acc_ff      <= acc_in;
      rsp_span_ff <= rsp_span_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_span_index  = rsp_span_ff;
   assign rsp_average     = rsp_avg_ff;
   assign rsp_range_error = rsp_err_ff;

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider result outside the divide state");

   // The result register is empty whenever the divider hands back a quotient.
   a_div_done_empty: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> !rsp_valid_ff)
      else $error("quotient would overwrite a pending result");

   // The averaging counter never reaches the degree.
   a_sum_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (cnt_ff < p))
      else $error("averaging ran past the degree");

   // A left search that has moved is always beyond its starting knot.
   a_left_moved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && !right_ff && moved_ff) |-> (i_ff > p_idx))
      else $error("left search index below its start");

endmodule

// ===== dv/bspline_knot_span_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bspline_knot_span_search: directed rows, then random knot
// vectors and queries, checked against an in-bench model of the knot store. Needs bks_pkg.

module bspline_knot_span_search_test;

   // Result fields of one answer, in the order the block reports them.
   typedef struct packed {
      logic [bks_pkg::KIDX_W-1:0]        span;
      logic signed [bks_pkg::DATA_W-1:0] mean;
      logic                              range_err;
   } knot_answer_type;

   // One row of the directed stimulus. When typed is set, the answer in the row is
   // the expectation; otherwise the in-bench model supplies it.
   typedef struct packed {
      logic [1:0]                        action;
      logic [1:0]                        mode;
      logic [bks_pkg::KIDX_W-1:0]        slot;
      logic signed [bks_pkg::DATA_W-1:0] value;
      logic                              typed;
      knot_answer_type                   answer;
   } directed_row_type;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_WAIT    = 16;
   localparam int STORE_DEPTH = bks_pkg::KNOTS_MAX_DEFAULT;
   localparam int NUM_PHASES  = 12;

   localparam logic signed [bks_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [bks_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [bks_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [1:0]                        req_action;
   logic [1:0]                        req_search_mode;
   logic [bks_pkg::KIDX_W-1:0]        req_knot_index;
   logic signed [bks_pkg::DATA_W-1:0] req_value;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [bks_pkg::KIDX_W-1:0]        rsp_span_index;
   logic signed [bks_pkg::DATA_W-1:0] rsp_average;
   logic                              rsp_range_error;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [bks_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [bks_pkg::CSR_DATA_W-1:0]    csr_data;

   bspline_knot_span_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_search_mode (req_search_mode),
      .req_knot_index  (req_knot_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_span_index  (rsp_span_index),
      .rsp_average     (rsp_average),
      .rsp_range_error (rsp_range_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Shadow copy of the block's state: the knot store and both registers.
   logic signed [bks_pkg::DATA_W-1:0] knot_mem [STORE_DEPTH];
   logic [bks_pkg::DEG_W-1:0]         deg_reg;
   logic [bks_pkg::CNT_W-1:0]         count_reg;

   // Answers the block owes us, oldest first.
   knot_answer_type answers_due [$];

   directed_row_type directed_rows [$];

   int  cycle_count = 0;
   int  mismatch_count;
   int  requests_sent;
   int  searches_sent;
   int  averages_sent;
   int  range_errors_seen;
   int  settings_done;
   bit  sender_quiet;
   bit  receiver_quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d answers outstanding.",
                  cycle_count, answers_due.size());
         $display("bspline_knot_span_search_test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // In-bench model of the block.
   // ------------------------------------------------------------------------

   // A degree of zero behaves as degree one.
   function automatic int live_degree();
      return (deg_reg == 0) ? 1 : int'(deg_reg);
   endfunction

   // The count register can hold more knots than the store has; the block caps it.
   function automatic int live_count();
      return (int'(count_reg) > STORE_DEPTH) ? STORE_DEPTH : int'(count_reg);
   endfunction

   // Linear walk from one end of the domain. The equal variants also stop at a
   // repeated knot, so a multiple knot is never walked through.
   function automatic logic [bks_pkg::KIDX_W-1:0] find_span(
         input logic [1:0] mode, input logic signed [bks_pkg::DATA_W-1:0] u);
      int n;
      int p;
      int k;
      n = live_count();
      p = live_degree();
      if (mode == bks_pkg::MODE_LEFT) begin
         k = p;
         while (k + 1 < n - p && u > knot_mem[k + 1]) k++;
      end else if (mode == bks_pkg::MODE_LEFT_EQ) begin
         k = p;
         while (k + 1 < n - p && u >= knot_mem[k + 1]) begin
            k++;
            if (knot_mem[k + 1] == knot_mem[k]) break;
         end
      end else begin
         // With too few knots for the degree the right walk starts at zero and stays.
         k = n - 1 - p;
         if (k < 0) k = 0;
         if (mode == bks_pkg::MODE_RIGHT) begin
            while (k - 1 > p && u < knot_mem[k - 1]) k--;
         end else begin
            while (k - 1 >= p && u <= knot_mem[k - 1]) begin
               k--;
               if (knot_mem[k - 1] == knot_mem[k]) break;
            end
         end
      end
      return k[bks_pkg::KIDX_W-1:0];
   endfunction

   // Mean of the degree knots after the base slot, truncated toward zero.
   function automatic knot_answer_type knot_mean(input int base);
      knot_answer_type ans;
      longint          sum;
      int              p;
      ans = '0;
      sum = 0;
      p = live_degree();
      if (base + p >= live_count()) begin
         ans.range_err = 1'b1;
      end else begin
         for (int j = base + 1; j <= base + p; j++) sum += longint'(knot_mem[j]);
         ans.mean = bks_pkg::DATA_W'(sum / longint'(p));
      end
      return ans;
   endfunction

   // Applies one accepted request to the shadow state and returns its answer.
   function automatic knot_answer_type knot_query_answer(
         input logic [1:0] action, input logic [1:0] mode,
         input logic [bks_pkg::KIDX_W-1:0] slot,
         input logic signed [bks_pkg::DATA_W-1:0] value);
      knot_answer_type ans;
      ans = '0;
      case (action)
         bks_pkg::ACT_WRITE:   knot_mem[slot] = value;
         bks_pkg::ACT_SEARCH:  ans.span = find_span(mode, value);
         bks_pkg::ACT_AVERAGE: ans = knot_mean(int'(slot));
         default:              ans = '0;
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Drives one request. It is entered just after a rising edge, and the next
   // falling edge always either lowers valid or presents a new payload, so an
   // accepted request is never seen twice.
   task automatic issue_request(input logic [1:0] action, input logic [1:0] mode,
                                input logic [bks_pkg::KIDX_W-1:0] slot,
                                input logic signed [bks_pkg::DATA_W-1:0] value,
                                input bit typed, input knot_answer_type typed_answer);
      int              gap;
      knot_answer_type ans;
      gap = sender_quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_search_mode <= mode;
      req_knot_index  <= slot;
      req_value       <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      ans = knot_query_answer(action, mode, slot, value);
      answers_due.push_back(typed ? typed_answer : ans);
      requests_sent++;
      if (action == bks_pkg::ACT_SEARCH) searches_sent++;
      if (action == bks_pkg::ACT_AVERAGE) averages_sent++;
      if ($urandom_range(0, 29) == 0) sender_quiet = !sender_quiet;
   endtask

   task automatic checked_request(input logic [1:0] action, input logic [1:0] mode,
                                  input logic [bks_pkg::KIDX_W-1:0] slot,
                                  input logic signed [bks_pkg::DATA_W-1:0] value);
      issue_request(action, mode, slot, value, 1'b0, '0);
   endtask

   // Holds off new requests until every answer owed has come back. Every request
   // yields an answer, so an empty queue means the block is idle; a few spare
   // cycles are added anyway.
   task automatic wait_for_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register while the block is idle and mirrors it in the model.
   task automatic write_register(input logic [bks_pkg::CSR_IDX_W-1:0] index,
                                 input logic [bks_pkg::CSR_DATA_W-1:0] data);
      wait_for_answers();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == bks_pkg::CSR_DEGREE) deg_reg = data[bks_pkg::DEG_W-1:0];
      else if (index == bks_pkg::CSR_KNOT_COUNT) count_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes a nondecreasing knot vector into the low slots. Repeated knots are
   // frequent, and a clamped vector repeats its end knots degree + 1 times.
   task automatic load_knot_vector(input int slots);
      longint knot;
      longint stride;
      bit     clamped;
      int     p;
      p = live_degree();
      clamped = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       stride = 1;
         1:       stride = 256;
         2:       stride = 65536;
         default: stride = 32'h0200_0000;
      endcase
      if ($urandom_range(0, 7) == 0) knot = longint'(Q_MIN);
      else knot = -longint'($urandom_range(0, 32'h7FFF_FFFF));
      for (int k = 0; k < slots; k++) begin
         if (k != 0 && !(clamped && (k <= p || k >= slots - p)) &&
             $urandom_range(0, 3) != 0) begin
            knot += longint'($urandom_range(1, int'(stride)));
         end
         if (knot > longint'(Q_MAX)) knot = longint'(Q_MAX);
         checked_request(bks_pkg::ACT_WRITE, 2'($urandom), k[bks_pkg::KIDX_W-1:0],
                         bks_pkg::DATA_W'(knot));
      end
   endtask

   // Query parameter: mostly a knot itself or a point inside the stored range,
   // sometimes anything at all or an end of the number range.
   function automatic logic signed [bks_pkg::DATA_W-1:0] pick_parameter();
      int                                n;
      longint                            lo;
      longint                            hi;
      longint                            tmp;
      longint unsigned                   draw;
      logic signed [bks_pkg::DATA_W-1:0] u;
      n = live_count();
      lo = longint'(knot_mem[0]);
      hi = longint'(knot_mem[(n > 0) ? n - 1 : 0]);
      if (lo > hi) begin
         tmp = lo;
         lo = hi;
         hi = tmp;
      end
      case ($urandom_range(0, 5))
         0, 1: u = knot_mem[$urandom_range(0, (n > 0) ? n - 1 : 0)];
         2, 3: begin
            draw = {$urandom, $urandom};
            u = bks_pkg::DATA_W'(lo + longint'(draw % unsigned'(hi - lo + 1)));
         end
         4:    u = $urandom;
         default: u = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      endcase
      return u;
   endfunction

   // A phase of random queries against the current settings. About one request
   // in eight is noise: an out-of-order knot or an unknown action.
   task automatic run_queries(input int count);
      int n;
      int p;
      int pick;
      int top;
      n = live_count();
      p = live_degree();
      top = n - p - 1;
      for (int k = 0; k < count; k++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 48) begin
            checked_request(bks_pkg::ACT_SEARCH, 2'($urandom), 6'($urandom),
                            pick_parameter());
         end else if (pick < 88) begin
            if (top >= 0 && $urandom_range(0, 3) != 0)
               checked_request(bks_pkg::ACT_AVERAGE, 2'($urandom),
                               6'($urandom_range(0, top)), $urandom);
            else
               checked_request(bks_pkg::ACT_AVERAGE, 2'($urandom), 6'($urandom), $urandom);
         end else if (pick < 94) begin
            checked_request(bks_pkg::ACT_WRITE, 2'($urandom), 6'($urandom), $urandom);
         end else begin
            checked_request(bks_pkg::ACT_NONE, 2'($urandom), 6'($urandom), $urandom);
         end
      end
   endtask

   function automatic directed_row_type make_row(
         input logic [1:0] action, input logic [1:0] mode,
         input logic [bks_pkg::KIDX_W-1:0] slot,
         input logic signed [bks_pkg::DATA_W-1:0] value,
         input bit typed,
         input logic [bks_pkg::KIDX_W-1:0] span,
         input logic signed [bks_pkg::DATA_W-1:0] mean,
         input logic range_err);
      directed_row_type row;
      row.action = action;
      row.mode = mode;
      row.slot = slot;
      row.value = value;
      row.typed = typed;
      row.answer.span = span;
      row.answer.mean = mean;
      row.answer.range_err = range_err;
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stalls, then an in-order check of every answer.
   // ------------------------------------------------------------------------

   task automatic note_mismatch(input string what, input knot_answer_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"Mismatch (%s) at cycle %0d: expected span %0d avg %h err %b,",
                   " got span %0d avg %h err %b"},
                  what, cycle_count, want.span, want.mean, want.range_err,
                  rsp_span_index, rsp_average, rsp_range_error);
   endtask

   initial begin
      int              stall_len;
      knot_answer_type want;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall_len = receiver_quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
         if (stall_len != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (stall_len - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         if (rsp_range_error === 1'b1) range_errors_seen++;
         if (answers_due.size() == 0) begin
            note_mismatch("answer with nothing pending", '0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_span_index !== want.span) note_mismatch("span_index", want);
            if (rsp_average !== want.mean) note_mismatch("average", want);
            if (rsp_range_error !== want.range_err) note_mismatch("range_error", want);
         end
         if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------

   initial begin
      int               deg_plan [NUM_PHASES];
      int               cnt_plan [NUM_PHASES];
      directed_row_type row;

      // Every input is known from time zero, while the block sits in reset.
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = bks_pkg::ACT_NONE;
      req_search_mode = bks_pkg::MODE_LEFT;
      req_knot_index  = '0;
      req_value       = '0;
      csr_valid       = 1'b0;
      csr_index       = bks_pkg::CSR_DEGREE;
      csr_data        = '0;
      mismatch_count  = 0;
      requests_sent   = 0;
      searches_sent   = 0;
      averages_sent   = 0;
      range_errors_seen = 0;
      settings_done   = 0;
      sender_quiet    = 1'b0;
      receiver_quiet  = 1'b0;
      deg_reg         = bks_pkg::DEGREE_RESET;
      count_reg       = bks_pkg::KNOT_COUNT_RESET;
      for (int k = 0; k < STORE_DEPTH; k++) knot_mem[k] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows run at the reset settings: degree 3 over eight knots.
      // The vector spans the whole number range, with a run of equal knots in the
      // middle and at the top. Writes, unknown actions, range errors and the
      // all-maximum average have answers that can be written down directly.
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 0, Q_MIN,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_RIGHT_EQ, 1, 0,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 2, 0,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 3, 0,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 4, Q_ONE,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 5, Q_MAX,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 6, Q_MAX,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_LEFT, 7, Q_MAX,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_LEFT, 0, Q_MIN,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_LEFT, 63, Q_MAX,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_LEFT_EQ, 5, Q_ONE,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_LEFT_EQ, 0, Q_MIN,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_RIGHT, 0, Q_MAX,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_RIGHT, 0, Q_MIN,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_RIGHT_EQ, 0, 0,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_SEARCH, bks_pkg::MODE_RIGHT_EQ, 0, Q_ONE,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_AVERAGE, bks_pkg::MODE_LEFT, 0, 0,
                                       0, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_AVERAGE, bks_pkg::MODE_LEFT, 4, 0,
                                       1, 0, Q_MAX, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_AVERAGE, bks_pkg::MODE_LEFT, 5, 0,
                                       1, 0, 0, 1));
      directed_rows.push_back(make_row(bks_pkg::ACT_AVERAGE, bks_pkg::MODE_RIGHT_EQ, 63, -1,
                                       1, 0, 0, 1));
      directed_rows.push_back(make_row(bks_pkg::ACT_NONE, bks_pkg::MODE_RIGHT_EQ, 63, -1,
                                       1, 0, 0, 0));
      directed_rows.push_back(make_row(bks_pkg::ACT_WRITE, bks_pkg::MODE_RIGHT_EQ, 63,
                                       32'sh1234_5678, 1, 0, 0, 0));

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         issue_request(row.action, row.mode, row.slot, row.value, row.typed, row.answer);
      end

      // Fill the whole store before the count is raised, so that no search or
      // average ever reads a slot that was never written.
      load_knot_vector(STORE_DEPTH);

      // Settings per phase: reset values, the smallest and largest legal ones,
      // degree zero, a count too small for the degree (the right walk starts at
      // zero), counts above the store size, and counts below the legal minimum.
      deg_plan = '{3, 1, 7, 0, 7, 5, 2, 4, 1, 7, 6, 3};
      cnt_plan = '{8, 2, 64, 20, 2, 127, 0, 1, 64, 15, 40, 33};

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // The upper data bits of a degree write are dropped by the register.
         write_register(bks_pkg::CSR_DEGREE,
                        {4'($urandom), deg_plan[ph][bks_pkg::DEG_W-1:0]});
         write_register(bks_pkg::CSR_KNOT_COUNT, bks_pkg::CSR_DATA_W'(cnt_plan[ph]));
         settings_done++;
         load_knot_vector(live_count());
         run_queries(60);
      end

      // Drain, then give the block time to show any stray answer.
      wait_for_answers();
      repeat (80) @(posedge clock);
      if (answers_due.size() != 0) begin
         mismatch_count += answers_due.size();
         $display("%0d answers never arrived.", answers_due.size());
      end

      $display("Ran %0d requests (%0d span searches, %0d averages, %0d range errors)",
               requests_sent, searches_sent, averages_sent, range_errors_seen);
      $display("over %0d register settings; mismatches: %0d, cycles: %0d.",
               settings_done, mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("bspline_knot_span_search_test passed");
      end else begin
         $display("bspline_knot_span_search_test failed");
      end
      $finish;
   end

endmodule
